### hdl/cmmcc_pkg.sv
// Package for the confusion matrix / MCC unit: widths, stream layout and
// sequencer state type. No dependencies.
package cmmcc_pkg;

  // counter and coefficient format
  localparam int unsigned COUNT_WIDTH   = 32;
  localparam int unsigned FRACTION_BITS = 14;
  localparam int unsigned HALVE_LIMIT   = 25000;

  // halved counts and the products built from them
  localparam int unsigned HALF_W = $clog2(HALVE_LIMIT + 1);
  localparam int unsigned SUM_W  = HALF_W + 1;
  localparam int unsigned PAIR_W = 2 * SUM_W;
  localparam int unsigned PROD_W = 2 * PAIR_W;
  localparam int unsigned ROOT_W = PROD_W / 2;
  localparam int unsigned MAG_W  = 2 * HALF_W;
  localparam int unsigned QUO_W  = FRACTION_BITS + 1;
  localparam int unsigned CORR_W = FRACTION_BITS + 2;

  // port fields
  localparam int unsigned THR_W      = 16;
  localparam int unsigned CORR_OUT_W = 16;
  localparam int unsigned CNT_OUT_W  = 32;
  localparam int unsigned CMP_W      = (CORR_W > THR_W) ? CORR_W : THR_W;

  localparam int unsigned IN_FIELDS_W  = 3;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = CORR_OUT_W + 2 + 4 * CNT_OUT_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic signed [THR_W-1:0] THR_RESET = 16'sd8192;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_HALVE,
    ST_MUL1,
    ST_MUL2,
    ST_ROOT_GO,
    ST_ROOT,
    ST_DIV,
    ST_DONE
  } cmmcc_state_e;

endpackage

### hdl/cmmcc_sqrt.sv
// Bit-serial floor square root, two radicand bits per cycle.
// Depends on cmmcc_pkg.
module cmmcc_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [cmmcc_pkg::PROD_W-1:0] radicand_i,
  output logic                        done_o,
  output logic [cmmcc_pkg::ROOT_W-1:0] root_o
);
  import cmmcc_pkg::*;

  localparam int unsigned REM_W = ROOT_W + 2;
  localparam int unsigned CNT_W = $clog2(ROOT_W);

  logic [PROD_W-1:0] rad_q, rad_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;

  assign rem_sh = {rem_q, rad_q[PROD_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root_q, 2'b01});

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[PROD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = REM_W'(rem_sh - trial);
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = REM_W'(rem_sh);
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(ROOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### hdl/cmmcc_div.sv
// Restoring divider, one quotient bit per cycle: (mag << FRACTION_BITS) / divisor.
// Needs mag <= divisor, so the quotient fits FRACTION_BITS+1 bits. Depends on cmmcc_pkg.
module cmmcc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [cmmcc_pkg::MAG_W-1:0]  mag_i,
  input  logic [cmmcc_pkg::ROOT_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [cmmcc_pkg::QUO_W-1:0]  quot_o
);
  import cmmcc_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUO_W);

  logic [ROOT_W-1:0] rem_q, rem_d;
  logic [ROOT_W-1:0] dvs_q, dvs_d;
  logic [QUO_W-1:0]  sh_q, sh_d;
  logic [QUO_W-1:0]  quot_q, quot_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ROOT_W:0]   rem_sh;

  assign rem_sh = {rem_q, sh_q[QUO_W-1]};

  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    sh_d   = sh_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // upper dividend bits (mag >> 1) are already below the divisor
      rem_d  = ROOT_W'(mag_i >> 1);
      dvs_d  = divisor_i;
      sh_d   = {mag_i[0], {(QUO_W-1){1'b0}}};
      quot_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      sh_d = {sh_q[QUO_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d  = ROOT_W'(rem_sh - {1'b0, dvs_q});
        quot_d = {quot_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_d  = ROOT_W'(rem_sh);
        quot_d = {quot_q[QUO_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(QUO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    sh_q   <= sh_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### hdl/confusion_matrix_mcc_unit.sv
// Top level of the confusion matrix / MCC unit: counters, halving shifter,
// multipliers and sequencer. Depends on cmmcc_pkg, cmmcc_sqrt and cmmcc_div.
//
// Each accepted input beat bumps one of four saturating counters (or clears
// them on restart) and yields one output beat with the four counts, the
// perfect flag, the Matthews correlation coefficient in signed Q2.14 and the
// threshold flag. One sample is processed at a time: it passes the halving
// shifter (one shift per cycle, up to 18 shifts), the bit-serial square
// root and the serial divider; when any marginal sum is zero the root and
// division are skipped. A new sample is accepted as soon as the sequencer
// is idle, even while the previous result still waits in the output
// register. The threshold register is written with cfg_we_i and may only
// change while no sample is in flight.
module confusion_matrix_mcc_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration: accuracy_threshold, signed Q2.14
  input  logic                             cfg_we_i,
  input  logic [cmmcc_pkg::THR_W-1:0]       cfg_wdata_i,
  // input stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [0] prediction_correct, [1] true_label, [2] restart, [7:3] zero
  input  logic [cmmcc_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // output stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [15:0] correlation, [16] perfect, [17] meets_threshold, [49:18] true_pos,
  // [81:50] true_neg, [113:82] false_pos, [145:114] false_neg, [151:146] zero
  output logic [cmmcc_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);
  import cmmcc_pkg::*;

  cmmcc_state_e state_q, state_d;

  logic [COUNT_WIDTH-1:0] tp_q, tn_q, fp_q, fn_q;
  logic [COUNT_WIDTH-1:0] h_tp_q, h_tn_q, h_fp_q, h_fn_q;
  logic [PAIR_W-1:0]      pa_q, pb_q;
  logic [MAG_W-1:0]       ma_q, mb_q;
  logic [PROD_W-1:0]      prod_q;
  logic [MAG_W-1:0]       mag_q;
  logic                   neg_q;
  logic                   zero_q;
  logic signed [THR_W-1:0] thr_q;
  logic                   m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q;

  logic in_fire;
  logic h_load, h_shift, mul1, mul2, root_start, out_load;
  logic over_limit;

  logic sample_correct, sample_positive, sample_restart;

  logic [HALF_W-1:0] x_tp, x_tn, x_fp, x_fn;
  logic [SUM_W-1:0]  s_tpfp, s_tpfn, s_tnfp, s_tnfn;

  logic              root_done, div_done;
  logic [ROOT_W-1:0] root;
  logic [QUO_W-1:0]  quot;

  logic signed [CORR_W-1:0] corr;
  logic signed [CMP_W-1:0]  corr_cmp, thr_cmp;
  logic                     perfect, meets;

  assign sample_correct  = s_axis_tdata_i[0];
  assign sample_positive = s_axis_tdata_i[1];
  assign sample_restart  = s_axis_tdata_i[2];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;

  assign over_limit = (h_tp_q > COUNT_WIDTH'(HALVE_LIMIT)) |
                      (h_tn_q > COUNT_WIDTH'(HALVE_LIMIT)) |
                      (h_fp_q > COUNT_WIDTH'(HALVE_LIMIT)) |
                      (h_fn_q > COUNT_WIDTH'(HALVE_LIMIT));

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    h_load     = 1'b0;
    h_shift    = 1'b0;
    mul1       = 1'b0;
    mul2       = 1'b0;
    root_start = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        h_load  = 1'b1;
        state_d = ST_HALVE;
      end
      ST_HALVE: begin
        if (over_limit) begin
          h_shift = 1'b1;
        end else begin
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        mul1    = 1'b1;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        mul2    = 1'b1;
        state_d = zero_q ? ST_DONE : ST_ROOT_GO;
      end
      ST_ROOT_GO: begin
        root_start = 1'b1;
        state_d    = ST_ROOT;
      end
      ST_ROOT: begin
        if (root_done) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // counters and threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tp_q  <= '0;
      tn_q  <= '0;
      fp_q  <= '0;
      fn_q  <= '0;
      thr_q <= THR_RESET;
    end else begin
      if (cfg_we_i) thr_q <= cfg_wdata_i;
      if (in_fire) begin
        if (sample_restart) begin
          tp_q <= '0;
          tn_q <= '0;
          fp_q <= '0;
          fn_q <= '0;
        end else if (sample_correct) begin
          if (sample_positive) begin
            if (tp_q != '1) tp_q <= tp_q + 1'b1;
          end else begin
            if (tn_q != '1) tn_q <= tn_q + 1'b1;
          end
        end else begin
          // wrong positive counts as false negative, wrong negative as false positive
          if (sample_positive) begin
            if (fn_q != '1) fn_q <= fn_q + 1'b1;
          end else begin
            if (fp_q != '1) fp_q <= fp_q + 1'b1;
          end
        end
      end
    end
  end

  assign x_tp = h_tp_q[HALF_W-1:0];
  assign x_tn = h_tn_q[HALF_W-1:0];
  assign x_fp = h_fp_q[HALF_W-1:0];
  assign x_fn = h_fn_q[HALF_W-1:0];

  assign s_tpfp = SUM_W'(x_tp) + SUM_W'(x_fp);
  assign s_tpfn = SUM_W'(x_tp) + SUM_W'(x_fn);
  assign s_tnfp = SUM_W'(x_tn) + SUM_W'(x_fp);
  assign s_tnfn = SUM_W'(x_tn) + SUM_W'(x_fn);

  // halving shifter and products
  always_ff @(posedge clk_i) begin
    if (h_load) begin
      h_tp_q <= tp_q;
      h_tn_q <= tn_q;
      h_fp_q <= fp_q;
      h_fn_q <= fn_q;
    end else if (h_shift) begin
      h_tp_q <= h_tp_q >> 1;
      h_tn_q <= h_tn_q >> 1;
      h_fp_q <= h_fp_q >> 1;
      h_fn_q <= h_fn_q >> 1;
    end
    if (mul1) begin
      pa_q   <= PAIR_W'(s_tpfp * s_tpfn);
      pb_q   <= PAIR_W'(s_tnfp * s_tnfn);
      ma_q   <= MAG_W'(x_tp * x_tn);
      mb_q   <= MAG_W'(x_fp * x_fn);
      zero_q <= (s_tpfp == '0) | (s_tpfn == '0) | (s_tnfp == '0) | (s_tnfn == '0);
    end
    if (mul2) begin
      prod_q <= PROD_W'(pa_q * pb_q);
      neg_q  <= (mb_q > ma_q);
      mag_q  <= (mb_q > ma_q) ? (mb_q - ma_q) : (ma_q - mb_q);
    end
  end

  cmmcc_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (prod_q),
    .done_o     (root_done),
    .root_o     (root)
  );

  // root is final and held once root_done pulses
  cmmcc_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (root_done),
    .mag_i     (mag_q),
    .divisor_i (root),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  // result assembly
  always_comb begin
    if (zero_q) begin
      corr = '0;
    end else if (neg_q) begin
      corr = -$signed(CORR_W'(quot));
    end else begin
      corr = $signed(CORR_W'(quot));
    end
  end

  assign corr_cmp = CMP_W'(corr);
  assign thr_cmp  = CMP_W'(thr_q);
  assign meets    = (corr_cmp >= thr_cmp);
  assign perfect  = ((tp_q | tn_q) != '0) & (fp_q == '0) & (fn_q == '0);

  always_comb begin
    m_valid_d = m_valid_q & ~m_axis_tready_i;
    if (out_load) m_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= OUT_TDATA_W'({CNT_OUT_W'(fn_q), CNT_OUT_W'(fp_q),
                                CNT_OUT_W'(tn_q), CNT_OUT_W'(tp_q),
                                meets, perfect, CORR_OUT_W'(corr)});
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

### bench/tb_confusion_matrix_mcc_unit.sv
`timescale 1ns / 1ps
// Testbench for confusion_matrix_mcc_unit: directed sample table, threshold sweeps,
// random sample streams and a long true-positive run, scored by an MCC predictor
// or by the typed rows' own results. Depends on cmmcc_pkg and the unit's RTL.
module tb_confusion_matrix_mcc_unit;
  import cmmcc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned DRAIN_WAIT  = 100;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned FILL_ITEMS  = 100;
  localparam int unsigned OFS_TP      = CORR_OUT_W + 2;
  localparam int unsigned OFS_TN      = OFS_TP + CNT_OUT_W;
  localparam int unsigned OFS_FP      = OFS_TN + CNT_OUT_W;
  localparam int unsigned OFS_FN      = OFS_FP + CNT_OUT_W;

  typedef struct packed {
    logic signed [CORR_OUT_W-1:0] corr;
    logic                         perfect;
    logic                         meets;
    logic [CNT_OUT_W-1:0]         tp;
    logic [CNT_OUT_W-1:0]         tn;
    logic [CNT_OUT_W-1:0]         fp;
    logic [CNT_OUT_W-1:0]         fn;
  } mcc_result_t;

  typedef struct packed {
    logic                    set_thr;
    logic signed [THR_W-1:0] thr;
    logic                    correct;
    logic                    label;
    logic                    restart;
    logic                    typed;
    mcc_result_t             want;
  } dir_row_t;

  // results that can be read straight off the counting rules
  localparam mcc_result_t NO_RES  = '0;
  localparam mcc_result_t R_ZERO  = '{16'sd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0};
  localparam mcc_result_t R_ZERO_M = '{16'sd0, 1'b0, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0};
  localparam mcc_result_t R_TP1   = '{16'sd0, 1'b1, 1'b0, 32'd1, 32'd0, 32'd0, 32'd0};
  localparam mcc_result_t R_ONE   = '{16'sd16384, 1'b1, 1'b1, 32'd1, 32'd1, 32'd0, 32'd0};
  localparam mcc_result_t R_FN1   = '{16'sd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd1};
  localparam mcc_result_t R_NEG   = '{-16'sd16384, 1'b0, 1'b0, 32'd0, 32'd0, 32'd1, 32'd1};
  localparam mcc_result_t R_FP1_M = '{16'sd0, 1'b0, 1'b1, 32'd0, 32'd0, 32'd1, 32'd0};
  localparam mcc_result_t R_NEG_M = '{-16'sd16384, 1'b0, 1'b1, 32'd0, 32'd0, 32'd1, 32'd1};

  localparam int unsigned DIR_N = 24;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // threshold at its reset value
    '{1'b0, 16'sd0,       1'b1, 1'b1, 1'b0, 1'b1, R_TP1},
    '{1'b0, 16'sd0,       1'b1, 1'b0, 1'b0, 1'b1, R_ONE},
    '{1'b0, 16'sd0,       1'b0, 1'b0, 1'b1, 1'b1, R_ZERO},
    '{1'b0, 16'sd0,       1'b0, 1'b1, 1'b0, 1'b1, R_FN1},
    '{1'b0, 16'sd0,       1'b0, 1'b0, 1'b0, 1'b1, R_NEG},
    // restart wins over the sample bits
    '{1'b0, 16'sd0,       1'b1, 1'b1, 1'b1, 1'b1, R_ZERO},
    '{1'b0, 16'sd0,       1'b1, 1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b0, 16'sd0,       1'b1, 1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b0, 16'sd0,       1'b1, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, 16'sd0,       1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, 16'sd0,       1'b0, 1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b0, 16'sd0,       1'b1, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b0, 16'sd0,       1'b0, 1'b0, 1'b0, 1'b0, NO_RES},
    // lowest threshold: restart and -1.0 both meet it
    '{1'b1, -16'sd16384,  1'b0, 1'b0, 1'b1, 1'b1, R_ZERO_M},
    '{1'b0, 16'sd0,       1'b0, 1'b0, 1'b0, 1'b1, R_FP1_M},
    '{1'b0, 16'sd0,       1'b0, 1'b1, 1'b0, 1'b1, R_NEG_M},
    '{1'b1, 16'sd16384,   1'b1, 1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b0, 16'sd0,       1'b1, 1'b0, 1'b0, 1'b0, NO_RES},
    '{1'b1, 16'sd0,       1'b0, 1'b1, 1'b1, 1'b1, R_ZERO_M},
    '{1'b0, 16'sd0,       1'b1, 1'b1, 1'b0, 1'b0, NO_RES},
    '{1'b0, 16'sd0,       1'b1, 1'b0, 1'b0, 1'b0, NO_RES},
    // highest threshold: only an exact +1.0 meets it
    '{1'b1, 16'sd16384,   1'b0, 1'b0, 1'b1, 1'b1, R_ZERO},
    '{1'b0, 16'sd0,       1'b1, 1'b1, 1'b0, 1'b1, R_TP1},
    '{1'b0, 16'sd0,       1'b1, 1'b0, 1'b0, 1'b1, R_ONE}
  };

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [THR_W-1:0]       cfg_wdata = '0;
  logic                   s_valid   = 1'b0;
  logic [IN_TDATA_W-1:0]  s_data    = '0;
  logic                   m_ready   = 1'b0;
  logic                   s_ready;
  logic                   m_valid;
  logic [OUT_TDATA_W-1:0] m_data;

  // values seen just before each rising edge
  logic                   in_beat  = 1'b0;
  logic                   out_beat = 1'b0;
  logic [OUT_TDATA_W-1:0] out_word = '0;

  logic [COUNT_WIDTH-1:0] cnt_tp = '0;
  logic [COUNT_WIDTH-1:0] cnt_tn = '0;
  logic [COUNT_WIDTH-1:0] cnt_fp = '0;
  logic [COUNT_WIDTH-1:0] cnt_fn = '0;
  logic signed [THR_W-1:0] thr_model = THR_RESET;

  mcc_result_t mcc_expect_q[$];

  bit          src_jitter    = 1'b1;
  bit          sink_jitter   = 1'b1;
  bit          hold_req      = 1'b0;
  int unsigned miss_cnt      = 0;
  int unsigned beats_checked = 0;
  int unsigned samples_sent  = 0;
  int unsigned restarts_sent = 0;
  int unsigned thr_writes    = 0;
  int unsigned fill_peak     = 0;
  int unsigned cycle_cnt     = 0;

  confusion_matrix_mcc_unit uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    in_beat  = s_valid && s_ready;
    out_beat = m_valid && m_ready;
    out_word = m_data;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit, %0d results still pending",
               mcc_expect_q.size());
      $display("FAIL confusion_matrix_mcc_unit");
      $finish;
    end
  end

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(logic [COUNT_WIDTH-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root, trial;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // updates the counter copy and returns the beat the unit should send
  function automatic mcc_result_t mcc_predict(logic correct, logic label, logic restart);
    mcc_result_t     r;
    longint unsigned h_tp, h_tn, h_fp, h_fn, prod, pos_term, neg_term, mag;
    longint          coef;
    if (restart) begin
      cnt_tp = '0;
      cnt_tn = '0;
      cnt_fp = '0;
      cnt_fn = '0;
    end else if (correct) begin
      if (label) cnt_tp = sat_inc(cnt_tp);
      else cnt_tn = sat_inc(cnt_tn);
    end else begin
      if (label) cnt_fn = sat_inc(cnt_fn);
      else cnt_fp = sat_inc(cnt_fp);
    end
    h_tp = 64'(cnt_tp);
    h_tn = 64'(cnt_tn);
    h_fp = 64'(cnt_fp);
    h_fn = 64'(cnt_fn);
    while (h_tp > HALVE_LIMIT || h_tn > HALVE_LIMIT || h_fp > HALVE_LIMIT ||
           h_fn > HALVE_LIMIT) begin
      h_tp = h_tp >> 1;
      h_tn = h_tn >> 1;
      h_fp = h_fp >> 1;
      h_fn = h_fn >> 1;
    end
    prod = (h_tp + h_fp) * (h_tp + h_fn) * (h_tn + h_fp) * (h_tn + h_fn);
    coef = 0;
    if (prod != 0) begin
      pos_term = h_tp * h_tn;
      neg_term = h_fp * h_fn;
      mag = (pos_term >= neg_term) ? pos_term - neg_term : neg_term - pos_term;
      coef = longint'((mag << FRACTION_BITS) / floor_root(prod));
      if (neg_term > pos_term) coef = -coef;
    end
    r.corr    = coef[CORR_OUT_W-1:0];
    r.perfect = (cnt_tp != 0 || cnt_tn != 0) && cnt_fp == 0 && cnt_fn == 0;
    r.meets   = coef >= longint'(thr_model);
    r.tp      = cnt_tp[CNT_OUT_W-1:0];
    r.tn      = cnt_tn[CNT_OUT_W-1:0];
    r.fp      = cnt_fp[CNT_OUT_W-1:0];
    r.fn      = cnt_fn[CNT_OUT_W-1:0];
    return r;
  endfunction

  // mostly back to back, sometimes a few cycles, rarely a long gap
  function automatic int unsigned pause_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  task automatic report_miss(string what, longint want, longint got);
    miss_cnt++;
    if (miss_cnt <= 10)
      $display("mismatch on %s at %0t ns: expected %0d, got %0d", what, $time, want, got);
  endtask

  always @(posedge clk) begin : scoreboard
    mcc_result_t want;
    mcc_result_t got;
    if (out_beat) begin
      got.corr    = out_word[CORR_OUT_W-1:0];
      got.perfect = out_word[CORR_OUT_W];
      got.meets   = out_word[CORR_OUT_W+1];
      got.tp      = out_word[OFS_TP +: CNT_OUT_W];
      got.tn      = out_word[OFS_TN +: CNT_OUT_W];
      got.fp      = out_word[OFS_FP +: CNT_OUT_W];
      got.fn      = out_word[OFS_FN +: CNT_OUT_W];
      if (mcc_expect_q.size() == 0) begin
        report_miss("result beat with nothing pending", 0, got.corr);
      end else begin
        want = mcc_expect_q.pop_front();
        beats_checked++;
        if (got.corr !== want.corr) report_miss("correlation", want.corr, got.corr);
        if (got.perfect !== want.perfect) report_miss("perfect", want.perfect, got.perfect);
        if (got.meets !== want.meets) report_miss("meets_threshold", want.meets, got.meets);
        if (got.tp !== want.tp) report_miss("true_pos", want.tp, got.tp);
        if (got.tn !== want.tn) report_miss("true_neg", want.tn, got.tn);
        if (got.fp !== want.fp) report_miss("false_pos", want.fp, got.fp);
        if (got.fn !== want.fn) report_miss("false_neg", want.fn, got.fn);
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : sink
    int unsigned n;
    forever begin
      @(posedge clk);
      n = 0;
      if (hold_req) begin
        hold_req = 1'b0;
        n = HOLD_CYCLES;
      end else if (sink_jitter && $urandom_range(0, 3) == 0) begin
        n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4) : $urandom_range(20, 80);
      end
      if (n != 0) begin
        m_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_ready <= 1'b1;
    end
  end

  // valid stays high after a beat when the next sample follows without a gap
  task automatic push_sample(logic correct, logic label, logic restart,
                             logic typed = 1'b0, mcc_result_t want = '0);
    int unsigned gap;
    mcc_result_t pred;
    gap = src_jitter ? pause_len() : 0;
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {{(IN_TDATA_W-3){1'b0}}, restart, label, correct};
    do @(posedge clk); while (!in_beat);
    pred = mcc_predict(correct, label, restart);
    mcc_expect_q.insert(mcc_expect_q.size(), typed ? want : pred);
    samples_sent++;
    if (restart) restarts_sent++;
  endtask

  // threshold only changes with the unit idle and every result delivered
  task automatic set_threshold(logic signed [THR_W-1:0] v);
    s_valid <= 1'b0;
    while (mcc_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    thr_model = v;
    thr_writes++;
  endtask

  task automatic run_random(int unsigned count, int unsigned pct_correct,
                            int unsigned pct_pos, int unsigned restart_pm,
                            int unsigned hold_at);
    for (int k = 0; k < count; k++) begin
      if (k == hold_at) hold_req = 1'b1;
      push_sample($urandom_range(0, 99) < pct_correct, $urandom_range(0, 99) < pct_pos,
                  $urandom_range(0, 999) < restart_pm);
    end
  endtask

  function automatic logic signed [THR_W-1:0] any_threshold();
    int pick;
    pick = int'($urandom_range(0, 32768)) - 16384;
    return THR_W'(pick);
  endfunction

  initial begin : stimulus
    logic signed [THR_W-1:0] thr;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < DIR_N; k++) begin
      if (DIR_ROWS[k].set_thr) set_threshold(DIR_ROWS[k].thr);
      push_sample(DIR_ROWS[k].correct, DIR_ROWS[k].label, DIR_ROWS[k].restart,
                  DIR_ROWS[k].typed, DIR_ROWS[k].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: thr = -16'sd16384;
        1: thr = 16'sd0;
        3: thr = 16'sd8192;
        5: thr = 16'sd16384;
        default: thr = any_threshold();
      endcase
      set_threshold(thr);
      // phase 3 runs with no idling on either side
      src_jitter  = (ph != 3);
      sink_jitter = (ph != 3);
      run_random(150, $urandom_range(5, 95), $urandom_range(10, 90), 20,
                 (ph == 1) ? 20 : 150);
    end

    // run of true positives (cheap: zero product), then mixed samples on top of it
    set_threshold(any_threshold());
    src_jitter  = 1'b0;
    sink_jitter = 1'b0;
    push_sample(1'b0, 1'b0, 1'b1);
    repeat (FILL_ITEMS) push_sample(1'b1, 1'b1, 1'b0);
    fill_peak   = cnt_tp;
    src_jitter  = 1'b1;
    sink_jitter = 1'b1;
    run_random(130, 60, 40, 0, 130);

    s_valid <= 1'b0;
    while (mcc_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d samples (%0d restarts) scored over %0d result beats, %0d mismatches",
             samples_sent, restarts_sent, beats_checked, miss_cnt);
    $display("%0d threshold writes; the long run took true positives to %0d",
             thr_writes, fill_peak);
    if (miss_cnt == 0) begin
      $display("PASS confusion_matrix_mcc_unit");
    end else begin
      $display("FAIL confusion_matrix_mcc_unit");
    end
    $finish;
  end

endmodule
